@@ hw/rtl/gdb_pkg.sv @@
// ============================================================================
// gdb_pkg: shared types, constants and calendar helpers
// Field widths, replacement date, reciprocal for divide-by-100 and the
// command word of the shared accumulator.
// ============================================================================
package gdb_pkg;

    localparam int DAY_W   = 5;
    localparam int MON_W   = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 22;
    // day numbers stay below 2**23; one extra bit carries the sign of a difference
    localparam int NUM_W   = 24;
    localparam int CENT_W  = 8;

    localparam logic [YEAR_W-1:0] MAX_YEAR = YEAR_W'(9999);

    // replacement for an invalid date: 1990-01-01
    localparam logic [DAY_W-1:0]  DEF_DAY   = DAY_W'(1);
    localparam logic [MON_W-1:0]  DEF_MONTH = MON_W'(1);
    localparam logic [YEAR_W-1:0] DEF_YEAR  = YEAR_W'(1990);

    localparam logic [MON_W-1:0] JAN = MON_W'(1);
    localparam logic [MON_W-1:0] FEB = MON_W'(2);
    localparam logic [MON_W-1:0] APR = MON_W'(4);
    localparam logic [MON_W-1:0] JUN = MON_W'(6);
    localparam logic [MON_W-1:0] SEP = MON_W'(9);
    localparam logic [MON_W-1:0] NOV = MON_W'(11);
    localparam logic [MON_W-1:0] DEC = MON_W'(12);

    // floor(y / 100) = (y * 5243) >> 19, exact for every 14-bit year
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);
    localparam int CENTURY     = 100;
    localparam int YEAR_DAYS   = 365;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        ALU_HOLD,
        ALU_LOAD,
        ALU_ADD,
        ALU_SUB,
        ALU_RSUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t            op;
        logic [NUM_W-1:0]   operand;
    } alu_cmd_t;

    function automatic logic [DAY_W-1:0] month_length(
        input logic [MON_W-1:0] month,
        input logic             leap
    );
        logic [DAY_W-1:0] len;
        if (month == APR || month == JUN || month == SEP || month == NOV)
        begin
            len = DAY_W'(30);
        end
        else if (month == FEB)
        begin
            len = leap ? DAY_W'(29) : DAY_W'(28);
        end
        else
        begin
            len = DAY_W'(31);
        end
        return len;
    endfunction

endpackage

@@ hw/rtl/gdb_div100.sv @@
// ============================================================================
// gdb_div100: century split of a year
// Two register stages: century = floor(year/100) by reciprocal multiply,
// then a flag for year being a whole multiple of 100. Year must stay put.
// ============================================================================
module gdb_div100
(
    input  logic                        clk,
    input  logic [gdb_pkg::YEAR_W-1:0]  year,
    output logic [gdb_pkg::CENT_W-1:0]  cent,
    output logic                        rem_zero
);

    localparam int PROD_W = gdb_pkg::YEAR_W + gdb_pkg::RECIP_W;

    logic [PROD_W-1:0]            prod;
    logic [gdb_pkg::CENT_W-1:0]   cent_reg;
    logic                         rem_zero_reg;
    logic [gdb_pkg::YEAR_W:0]     back_mult;

    assign prod      = PROD_W'(year) * PROD_W'(gdb_pkg::RECIP_100);
    assign back_mult = (gdb_pkg::YEAR_W+1)'(cent_reg) * (gdb_pkg::YEAR_W+1)'(gdb_pkg::CENTURY);

    always_ff @(posedge clk)
    begin
        cent_reg     <= prod[gdb_pkg::RECIP_SHIFT +: gdb_pkg::CENT_W];
        rem_zero_reg <= (back_mult == (gdb_pkg::YEAR_W+1)'(year));
    end

    assign cent     = cent_reg;
    assign rem_zero = rem_zero_reg;

endmodule

@@ hw/rtl/gdb_alu.sv @@
// ============================================================================
// gdb_alu: shared accumulator
// One adder/subtractor with a result register; every day-number step and
// the final difference go through it.
// ============================================================================
module gdb_alu
(
    input  logic                       clk,
    input  gdb_pkg::alu_cmd_t          cmd,
    output logic [gdb_pkg::NUM_W-1:0]  acc
);

    logic [gdb_pkg::NUM_W-1:0] acc_reg;
    logic [gdb_pkg::NUM_W-1:0] acc_next;

    always_comb
    begin
        unique case (cmd.op)
            gdb_pkg::ALU_HOLD: acc_next = acc_reg;
            gdb_pkg::ALU_LOAD: acc_next = cmd.operand;
            gdb_pkg::ALU_ADD:  acc_next = acc_reg + cmd.operand;
            gdb_pkg::ALU_SUB:  acc_next = acc_reg - cmd.operand;
            gdb_pkg::ALU_RSUB: acc_next = cmd.operand - acc_reg;
            default:           acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

@@ hw/rtl/gregorian_days_between.sv @@
// ============================================================================
// gregorian_days_between: days between two Gregorian dates
// Validates both dates (invalid -> 1990-01-01), turns each into a day number
// counted from 0000-01-01 on one shared accumulator, and reports |n2 - n1|
// plus whether the first date is strictly earlier.
// ============================================================================
//
//  channel  | handshake           | word
//  ---------+---------------------+-------------------------------------------
//  command  | start / busy        | first_day/month/year, second_day/month/year
//  result   | done (1-cycle)      | day_count, first_is_earlier
//
// One word at a time. A word is taken on a rising edge with start high and
// busy low; busy then stays high until the result cycle.
// Per date: century split and check (redone if the date is replaced), year
// terms, then m-1 month adds and one day add, m being the validated month.
// After both dates: difference, absolute value, output. The time from accept
// to done thus depends on the validated month of each date, set by the month
// walk on the accumulator, and on whether a date is replaced.
// done is high for one cycle; the receiver cannot stall it.
// Reset (rst_n low, asynchronous) returns to idle with no result pending.
//
module gregorian_days_between
#(
    parameter logic [gdb_pkg::YEAR_W-1:0]       MAX_YEAR = gdb_pkg::MAX_YEAR
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [gdb_pkg::DAY_W-1:0]           first_day,
    input  logic [gdb_pkg::MON_W-1:0]           first_month,
    input  logic [gdb_pkg::YEAR_W-1:0]          first_year,
    input  logic [gdb_pkg::DAY_W-1:0]           second_day,
    input  logic [gdb_pkg::MON_W-1:0]           second_month,
    input  logic [gdb_pkg::YEAR_W-1:0]          second_year,
    output logic                                done,
    output logic [gdb_pkg::COUNT_W-1:0]         day_count,
    output logic                                first_is_earlier
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,      // century split, stage one
        S_CHK,      // multiple-of-100 flag
        S_VAL,      // validate or replace the date
        S_BASE,     // 365 * y
        S_Q4,       // + ceil(y/4)
        S_Q100,     // - ceil(y/100)
        S_Q400,     // + ceil(y/400)
        S_MON,      // whole months, then the day of month
        S_DIFF,     // n2 - n1
        S_ABS,
        S_FIN
    } state_t;

    state_t                         state_reg;
    logic                           sel_reg;      // 0: first date, 1: second date
    logic [gdb_pkg::MON_W-1:0]      mon_k_reg;
    logic [gdb_pkg::DAY_W-1:0]      d1_reg, d2_reg;
    logic [gdb_pkg::MON_W-1:0]      m1_reg, m2_reg;
    logic [gdb_pkg::YEAR_W-1:0]     y1_reg, y2_reg;
    logic [gdb_pkg::NUM_W-1:0]      n1_reg;
    logic                           done_reg;
    logic                           earlier_reg;
    logic [gdb_pkg::COUNT_W-1:0]    count_reg;

    logic [gdb_pkg::DAY_W-1:0]      cur_d;
    logic [gdb_pkg::MON_W-1:0]      cur_m;
    logic [gdb_pkg::YEAR_W-1:0]     cur_y;
    logic [gdb_pkg::CENT_W-1:0]     cent;
    logic                           rem_zero;
    logic                           leap;
    logic                           date_ok;
    logic                           c4_zero;
    logic [gdb_pkg::YEAR_W:0]       y_plus3;
    gdb_pkg::alu_cmd_t              alu_cmd;
    logic [gdb_pkg::NUM_W-1:0]      acc;
    logic                           acc_neg;

    assign cur_d = sel_reg ? d2_reg : d1_reg;
    assign cur_m = sel_reg ? m2_reg : m1_reg;
    assign cur_y = sel_reg ? y2_reg : y1_reg;

    gdb_div100 u_div100
    (
        .clk      (clk),
        .year     (cur_y),
        .cent     (cent),
        .rem_zero (rem_zero)
    );

    gdb_alu u_alu
    (
        .clk (clk),
        .cmd (alu_cmd),
        .acc (acc)
    );

    // leap: y%4==0 and (y%100!=0 or y%400==0); y%400==0 iff century%4==0
    assign c4_zero = (cent[1:0] == 2'b00);
    assign leap    = (cur_y[1:0] == 2'b00) && (!rem_zero || c4_zero);
    assign date_ok = (cur_m >= gdb_pkg::JAN) && (cur_m <= gdb_pkg::DEC) &&
                     (cur_y <= MAX_YEAR) && (cur_d != '0) &&
                     (cur_d <= gdb_pkg::month_length(cur_m, leap));
    assign y_plus3 = (gdb_pkg::YEAR_W+1)'(cur_y) + (gdb_pkg::YEAR_W+1)'(3);
    assign acc_neg = acc[gdb_pkg::NUM_W-1];

    // accumulator command per step
    always_comb
    begin
        alu_cmd.op      = gdb_pkg::ALU_HOLD;
        alu_cmd.operand = '0;
        unique case (state_reg)
            S_BASE:
            begin
                alu_cmd.op      = gdb_pkg::ALU_LOAD;
                alu_cmd.operand = gdb_pkg::NUM_W'(cur_y) *
                                  gdb_pkg::NUM_W'(gdb_pkg::YEAR_DAYS);
            end
            S_Q4:
            begin
                alu_cmd.op      = gdb_pkg::ALU_ADD;
                alu_cmd.operand = gdb_pkg::NUM_W'(y_plus3 >> 2);
            end
            S_Q100:
            begin
                alu_cmd.op      = gdb_pkg::ALU_SUB;
                alu_cmd.operand = gdb_pkg::NUM_W'(cent) + gdb_pkg::NUM_W'(!rem_zero);
            end
            S_Q400:
            begin
                alu_cmd.op      = gdb_pkg::ALU_ADD;
                alu_cmd.operand = gdb_pkg::NUM_W'(cent >> 2) +
                                  gdb_pkg::NUM_W'(!(rem_zero && c4_zero));
            end
            S_MON:
            begin
                alu_cmd.op = gdb_pkg::ALU_ADD;
                if (mon_k_reg < cur_m)
                begin
                    alu_cmd.operand = gdb_pkg::NUM_W'(gdb_pkg::month_length(mon_k_reg, leap));
                end
                else
                begin
                    alu_cmd.operand = gdb_pkg::NUM_W'(cur_d) - gdb_pkg::NUM_W'(1);
                end
            end
            S_DIFF:
            begin
                alu_cmd.op      = gdb_pkg::ALU_SUB;
                alu_cmd.operand = n1_reg;
            end
            S_ABS:
            begin
                // negate when negative: 0 - acc
                alu_cmd.op      = acc_neg ? gdb_pkg::ALU_RSUB : gdb_pkg::ALU_HOLD;
                alu_cmd.operand = '0;
            end
            default:
            begin
                alu_cmd.op      = gdb_pkg::ALU_HOLD;
                alu_cmd.operand = '0;
            end
        endcase
    end

    // sequencer, input capture and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            sel_reg     <= 1'b0;
            mon_k_reg   <= gdb_pkg::JAN;
            done_reg    <= 1'b0;
            earlier_reg <= 1'b0;
            count_reg   <= '0;
            d1_reg      <= '0;
            m1_reg      <= '0;
            y1_reg      <= '0;
            d2_reg      <= '0;
            m2_reg      <= '0;
            y2_reg      <= '0;
            n1_reg      <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        d1_reg    <= first_day;
                        m1_reg    <= first_month;
                        y1_reg    <= first_year;
                        d2_reg    <= second_day;
                        m2_reg    <= second_month;
                        y2_reg    <= second_year;
                        sel_reg   <= 1'b0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    // accumulator still holds n1 while the second date starts
                    if (sel_reg)
                    begin
                        n1_reg <= acc;
                    end
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    state_reg <= S_VAL;
                end
                S_VAL:
                begin
                    if (date_ok)
                    begin
                        state_reg <= S_BASE;
                    end
                    else
                    begin
                        // replace and redo the century split for the new year
                        if (sel_reg)
                        begin
                            d2_reg <= gdb_pkg::DEF_DAY;
                            m2_reg <= gdb_pkg::DEF_MONTH;
                            y2_reg <= gdb_pkg::DEF_YEAR;
                        end
                        else
                        begin
                            d1_reg <= gdb_pkg::DEF_DAY;
                            m1_reg <= gdb_pkg::DEF_MONTH;
                            y1_reg <= gdb_pkg::DEF_YEAR;
                        end
                        state_reg <= S_MUL;
                    end
                end
                S_BASE:
                begin
                    state_reg <= S_Q4;
                end
                S_Q4:
                begin
                    state_reg <= S_Q100;
                end
                S_Q100:
                begin
                    state_reg <= S_Q400;
                end
                S_Q400:
                begin
                    mon_k_reg <= gdb_pkg::JAN;
                    state_reg <= S_MON;
                end
                S_MON:
                begin
                    if (mon_k_reg < cur_m)
                    begin
                        mon_k_reg <= mon_k_reg + gdb_pkg::MON_W'(1);
                    end
                    else if (sel_reg)
                    begin
                        state_reg <= S_DIFF;
                    end
                    else
                    begin
                        sel_reg   <= 1'b1;
                        state_reg <= S_MUL;
                    end
                end
                S_DIFF:
                begin
                    state_reg <= S_ABS;
                end
                S_ABS:
                begin
                    // acc = n2 - n1 here
                    earlier_reg <= !acc_neg && (acc != '0);
                    state_reg   <= S_FIN;
                end
                S_FIN:
                begin
                    if (acc[gdb_pkg::NUM_W-1:gdb_pkg::COUNT_W] != '0)
                    begin
                        count_reg <= gdb_pkg::COUNT_MAX;
                    end
                    else
                    begin
                        count_reg <= acc[gdb_pkg::COUNT_W-1:0];
                    end
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy             = (state_reg != S_IDLE);
    assign done             = done_reg;
    assign day_count        = count_reg;
    assign first_is_earlier = earlier_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg == S_FIN) && !busy))
        else $error("result strobe outside the final step");

    a_earlier_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && first_is_earlier) |-> (day_count != '0))
        else $error("earlier flag with zero day count");

    a_month_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MON) |-> (mon_k_reg <= cur_m && cur_m <= gdb_pkg::DEC))
        else $error("month walk ran past the validated month");

endmodule
